/* rtl/atu_pkg.sv */
// shared types and constants of the three-timer unit
package atu_pkg;

  localparam int NUM_TIMERS = 3;
  localparam int IDX_W      = 2;
  localparam int CYC_W      = 4;
  localparam int VAL_W      = 8;
  localparam int STAGE_W    = 8;
  localparam int OUT_W      = 4;

  localparam int SLOW_PERIOD = 128;
  localparam int FAST_PERIOD = 16;
  localparam int SLOW_W      = 8;
  localparam int FAST_W      = 5;

  // highest valid timer index, anything above flags an error
  localparam logic [IDX_W-1:0] LAST_TIMER = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_READ    = 2'd1,
    OP_WR_DIV  = 2'd2,
    OP_SET_EN  = 2'd3
  } op_t;

  // one beat's worth of control for a single timer
  typedef struct packed {
    logic             tick;
    logic             sel;
    op_t              op;
    logic [VAL_W-1:0] value;
  } timer_cmd_t;

  typedef struct packed {
    logic slow;
    logic fast;
  } ticks_t;

endpackage

/* rtl/atu_if.sv */
// request and response channel interfaces of the three-timer unit
interface atu_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [atu_pkg::IDX_W-1:0] timer_index;
  logic [atu_pkg::CYC_W-1:0] cycles;
  logic [atu_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output timer_index, output cycles,
                  output value, input ready);
  modport sink   (input valid, input op, input timer_index, input cycles,
                  input value, output ready);
endinterface

interface atu_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [atu_pkg::OUT_W-1:0] read_data;
  logic                      bad_index;

  modport source (output valid, output read_data, output bad_index, input ready);
  modport sink   (input valid, input read_data, input bad_index, output ready);
endinterface

/* rtl/atu_prescaler.sv */
// slow and fast prescalers, each giving at most one tick per advance
module atu_prescaler (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [atu_pkg::CYC_W-1:0] cycles,
  output atu_pkg::ticks_t           ticks
);

  localparam int SLOW_SUM_W = atu_pkg::SLOW_W + 1;
  localparam int FAST_SUM_W = atu_pkg::FAST_W + 1;
  localparam logic [SLOW_SUM_W-1:0] SLOW_MAX = SLOW_SUM_W'((1 << atu_pkg::SLOW_W) - 1);
  localparam logic [FAST_SUM_W-1:0] FAST_MAX = FAST_SUM_W'((1 << atu_pkg::FAST_W) - 1);
  localparam logic [SLOW_SUM_W-1:0] SLOW_P   = SLOW_SUM_W'(atu_pkg::SLOW_PERIOD);
  localparam logic [FAST_SUM_W-1:0] FAST_P   = FAST_SUM_W'(atu_pkg::FAST_PERIOD);

  logic [atu_pkg::SLOW_W-1:0] slow_acc;
  logic [atu_pkg::FAST_W-1:0] fast_acc;
  logic [atu_pkg::SLOW_W-1:0] slow_acc_next;
  logic [atu_pkg::FAST_W-1:0] fast_acc_next;
  logic [SLOW_SUM_W-1:0]      slow_sum;
  logic [FAST_SUM_W-1:0]      fast_sum;
  logic [SLOW_SUM_W-1:0]      slow_rem;
  logic [FAST_SUM_W-1:0]      fast_rem;

  always_comb begin
    slow_sum   = {1'b0, slow_acc} + SLOW_SUM_W'(cycles);
    fast_sum   = {1'b0, fast_acc} + FAST_SUM_W'(cycles);
    ticks.slow = advance && (slow_sum >= SLOW_P);
    ticks.fast = advance && (fast_sum >= FAST_P);
    slow_rem   = ticks.slow ? slow_sum - SLOW_P : slow_sum;
    fast_rem   = ticks.fast ? fast_sum - FAST_P : fast_sum;
    // leftover beyond one period piles up and saturates
    slow_acc_next = (slow_rem > SLOW_MAX) ? SLOW_MAX[atu_pkg::SLOW_W-1:0]
                                          : slow_rem[atu_pkg::SLOW_W-1:0];
    fast_acc_next = (fast_rem > FAST_MAX) ? FAST_MAX[atu_pkg::FAST_W-1:0]
                                          : fast_rem[atu_pkg::FAST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_acc <= '0;
      fast_acc <= '0;
    end else if (advance) begin
      slow_acc <= slow_acc_next;
      fast_acc <= fast_acc_next;
    end
  end

endmodule

/* rtl/atu_timer.sv */
// one timer: stage counter, output counter, divider and enable
module atu_timer (
  input  logic                      clk,
  input  logic                      rst,
  input  atu_pkg::timer_cmd_t       cmd,
  output logic [atu_pkg::OUT_W-1:0] out_count
);

  logic [atu_pkg::STAGE_W-1:0] stage_count;
  logic [atu_pkg::STAGE_W-1:0] divider;
  logic                        enabled;
  logic [atu_pkg::STAGE_W-1:0] stage_inc;
  logic                        fire;
  logic                        turn_on;

  assign stage_inc = stage_count + 1'b1;
  assign fire      = enabled && (stage_inc >= divider);
  assign turn_on   = !enabled && cmd.value[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= '0;
      out_count   <= '0;
      divider     <= '0;
      enabled     <= 1'b0;
    end else if (cmd.tick) begin
      stage_count <= fire ? '0 : stage_inc;
      if (fire) begin
        out_count <= out_count + 1'b1;
      end
    end else if (cmd.sel) begin
      case (cmd.op)
        atu_pkg::OP_READ: begin
          out_count <= '0;
        end
        atu_pkg::OP_WR_DIV: begin
          divider <= cmd.value;
        end
        atu_pkg::OP_SET_EN: begin
          // counters clear only on the off to on edge
          if (turn_on) begin
            stage_count <= '0;
            out_count   <= '0;
          end
          enabled <= cmd.value[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/audio_cpu_three_timer_unit.sv */
// Three-timer unit with slow and fast prescalers. Takes one request beat per
// clock and returns one response per request, in order. A request is held in
// an input register, then its effect on the timers and its response are
// registered together in the response register, once the response side is
// free to take the beat on from the input register;
// throughput is one beat per cycle while the response side keeps taking beats,
// set by the single input stage and the response register. While a response
// waits, the input register holds its beat and the input takes no more.
module audio_cpu_three_timer_unit (
  input  logic       clk,
  input  logic       rst,
  atu_req_if.sink    req,
  atu_rsp_if.source  rsp
);

  logic                      s1_valid;
  atu_pkg::op_t              s1_op;
  logic [atu_pkg::IDX_W-1:0] s1_idx;
  logic [atu_pkg::CYC_W-1:0] s1_cycles;
  logic [atu_pkg::VAL_W-1:0] s1_value;

  logic                      s1_go;
  logic                      is_adv;
  logic                      bad;
  logic [atu_pkg::OUT_W-1:0] rd_data;
  atu_pkg::ticks_t           ticks;
  atu_pkg::timer_cmd_t       cmd [atu_pkg::NUM_TIMERS];
  logic [atu_pkg::OUT_W-1:0] counts [atu_pkg::NUM_TIMERS];

  assign s1_go     = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op     <= atu_pkg::op_t'(req.op);
      s1_idx    <= req.timer_index;
      s1_cycles <= req.cycles;
      s1_value  <= req.value;
    end
  end

  assign is_adv = (s1_op == atu_pkg::OP_ADVANCE);
  assign bad    = !is_adv && (s1_idx > atu_pkg::LAST_TIMER);

  atu_prescaler u_prescaler (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_go && is_adv),
    .cycles  (s1_cycles),
    .ticks   (ticks)
  );

  // timers 0 and 1 run off the slow prescaler, timer 2 off the fast one
  for (genvar t = 0; t < atu_pkg::NUM_TIMERS; t++) begin : g_timer
    always_comb begin
      cmd[t].tick  = (t == atu_pkg::NUM_TIMERS - 1) ? ticks.fast : ticks.slow;
      cmd[t].sel   = s1_go && !is_adv && (s1_idx == atu_pkg::IDX_W'(t));
      cmd[t].op    = s1_op;
      cmd[t].value = s1_value;
    end

    atu_timer u_timer (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd[t]),
      .out_count (counts[t])
    );
  end

  always_comb begin
    rd_data = '0;
    if (s1_op == atu_pkg::OP_READ) begin
      for (int t = 0; t < atu_pkg::NUM_TIMERS; t++) begin
        if (s1_idx == atu_pkg::IDX_W'(t)) begin
          rd_data = counts[t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      rsp.read_data <= rd_data;
      rsp.bad_index <= bad;
    end
  end

endmodule
